// ----- rtl/csmeta_pkg.sv -----
// Shared types, constants and helper functions of the cache set metadata store.
package csmeta_pkg;

  // Number of sets in the metadata store.
  localparam int NUM_SETS = 1024;

  // Width of the incoming set index field.
  localparam int SET_IDX_W = 10;

  // Address width of the metadata memory.
  localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  // Field widths of one metadata entry.
  localparam int WAYS    = 4;
  localparam int PLRU_W  = 3;
  localparam int META_W  = 2 * WAYS + PLRU_W;

  // Last address of the clearing pass.
  localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(NUM_SETS - 1);

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    MODE_TOUCH     = 2'd0,
    MODE_DIRTY_WR  = 2'd1,
    MODE_VALID_WR  = 2'd2,
    MODE_VALID_RD  = 2'd3
  } mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // Input beat payload.
  typedef struct packed {
    mode_e                mode;
    logic [SET_IDX_W-1:0] set_index;
    logic [1:0]           way;
    logic                 bit_value;
  } in_t;

  // Output beat payload.
  typedef struct packed {
    logic              valid_bit;
    logic [WAYS-1:0]   valid_mask;
    logic [WAYS-1:0]   dirty_mask;
    logic [PLRU_W-1:0] plru_bits;
  } out_t;

  // One metadata entry as stored in memory.
  typedef struct packed {
    logic [WAYS-1:0]   valid;
    logic [WAYS-1:0]   dirty;
    logic [PLRU_W-1:0] plru;
  } meta_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sts_t;

  // Tree PLRU update: b2 picks the half, b0 covers ways 0/1, b1 covers ways 2/3.
  function automatic logic [PLRU_W-1:0] plru_after_touch(logic [PLRU_W-1:0] plru,
                                                         logic [1:0] way);
    logic [PLRU_W-1:0] res;
    unique case (way)
      2'd0:    res = {1'b0, plru[1], 1'b0};
      2'd1:    res = {1'b0, plru[1], 1'b1};
      2'd2:    res = {1'b1, 1'b0, plru[0]};
      default: res = {1'b1, 1'b1, plru[0]};
    endcase
    return res;
  endfunction

  // Set one way's bit in a mask to the given value.
  function automatic logic [WAYS-1:0] put_bit(logic [WAYS-1:0] mask, logic [1:0] way,
                                              logic value);
    logic [WAYS-1:0] res;
    res      = mask;
    res[way] = value;
    return res;
  endfunction

  // Fold a set index into the store by restoring compare and subtract steps.
  function automatic logic [SET_AW-1:0] wrap_index(logic [SET_IDX_W-1:0] idx);
    logic [SET_IDX_W-1:0] r;
    r = idx;
    if (NUM_SETS < (1 << SET_IDX_W)) begin
      for (int k = SET_IDX_W - 1; k >= 0; k--) begin
        if (int'(r) >= (NUM_SETS << k)) begin
          r = r - SET_IDX_W'(NUM_SETS << k);
        end
      end
    end
    return SET_AW'(r);
  endfunction

endpackage

// ----- rtl/csmeta_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module csmeta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/csmeta_ctrl.sv -----
// Controller state machine: clearing pass, beat acceptance and entry update.
module csmeta_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csmeta_pkg::sts_t   sts_i,
  output csmeta_pkg::cmd_t   cmd_o
);

  csmeta_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csmeta_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      csmeta_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = csmeta_pkg::ST_IDLE;
        end
      end
      csmeta_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = csmeta_pkg::ST_UPDATE;
        end
      end
      csmeta_pkg::ST_UPDATE: begin
        // Wait until the output register can take the result.
        if (!sts_i.out_busy) begin
          cmd_o.update = 1'b1;
          state_d      = csmeta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csmeta_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/csmeta_dp.sv -----
// Datapath: metadata memory, clear counter, read-modify-write and output register.
module csmeta_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csmeta_pkg::in_t   in_data_i,
  input  csmeta_pkg::cmd_t  cmd_i,
  output csmeta_pkg::sts_t  sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csmeta_pkg::out_t  out_data_o
);

  logic [csmeta_pkg::SET_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [csmeta_pkg::SET_AW-1:0] idx_q;
  logic [csmeta_pkg::SET_AW-1:0] rd_idx;
  csmeta_pkg::mode_e             mode_q;
  logic [1:0]                    way_q;
  logic                          bit_q;
  logic [csmeta_pkg::META_W-1:0] rdata;
  csmeta_pkg::meta_t             old_meta;
  csmeta_pkg::meta_t             new_meta;
  logic                          we;
  logic [csmeta_pkg::SET_AW-1:0] waddr;
  logic [csmeta_pkg::META_W-1:0] wdata;
  logic                          out_valid_q, out_valid_d;
  csmeta_pkg::out_t              out_q;

  assign rd_idx = csmeta_pkg::wrap_index(in_data_i.set_index);

  // Clearing pass address counter.
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clear_wr) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q  <= rd_idx;
      mode_q <= in_data_i.mode;
      way_q  <= in_data_i.way;
      bit_q  <= in_data_i.bit_value;
    end
  end

  // Metadata memory.
  csmeta_ram #(
    .WIDTH (csmeta_pkg::META_W),
    .DEPTH (csmeta_pkg::NUM_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  // Apply the operation to the entry read back.
  always_comb begin
    old_meta = csmeta_pkg::meta_t'(rdata);
    new_meta = old_meta;
    unique case (mode_q)
      csmeta_pkg::MODE_TOUCH:
        new_meta.plru = csmeta_pkg::plru_after_touch(old_meta.plru, way_q);
      csmeta_pkg::MODE_DIRTY_WR:
        new_meta.dirty = csmeta_pkg::put_bit(old_meta.dirty, way_q, bit_q);
      csmeta_pkg::MODE_VALID_WR:
        new_meta.valid = csmeta_pkg::put_bit(old_meta.valid, way_q, bit_q);
      default: ;
    endcase
  end

  // Write port: zeros during the clearing pass, updated entry otherwise.
  assign we    = cmd_i.clear_wr | cmd_i.update;
  assign waddr = cmd_i.clear_wr ? clr_cnt_q : idx_q;
  assign wdata = cmd_i.clear_wr ? '0 : csmeta_pkg::META_W'(new_meta);

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.update) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q.valid_bit  <= new_meta.valid[way_q];
      out_q.valid_mask <= new_meta.valid;
      out_q.dirty_mask <= new_meta.dirty;
      out_q.plru_bits  <= new_meta.plru;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign sts_o.clear_last = (clr_cnt_q == csmeta_pkg::LAST_SET);
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // The output register is never overwritten while a stalled beat waits in it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> !(out_valid_q && out_stall_i))
    else $error("update while output beat is stalled");

  // An update always leaves a beat in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> out_valid_q)
    else $error("update did not produce an output beat");

  // The clearing pass never overlaps beat traffic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_wr |-> !(cmd_i.update || cmd_i.accept))
    else $error("beat traffic during clearing pass");

  // The clear counter only moves during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clear_wr |=> $stable(clr_cnt_q))
    else $error("clear counter moved outside clearing pass");

endmodule

// ----- rtl/cache_set_valid_dirty_plru_store_top.sv -----
// Top level of the cache set metadata store (valid, dirty and tree PLRU bits per set).
//
//   Port group   Direction  Handshake                Payload
//   in_*         input      in_valid_i/in_stall_o    csmeta_pkg::in_t
//   out_*        output     out_valid_o/out_stall_i  csmeta_pkg::out_t
//
// For each beat the set's entry is first read from the metadata memory, then it is
// written back and the output register is loaded; the memory read is registered.
// After reset a clearing pass writes zeros to all NUM_SETS entries, one per cycle,
// and in_stall_o stays high until it ends.
// A stalled output holds its beat; the next input beat is still taken, and its
// write-back waits until the output register is free.
module cache_set_valid_dirty_plru_store_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csmeta_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output csmeta_pkg::out_t out_data_o
);

  csmeta_pkg::cmd_t cmd;
  csmeta_pkg::sts_t sts;

  // Controller.
  csmeta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  csmeta_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for the cache set metadata store: random and directed accesses checked beat by beat.
`timescale 1ns / 100ps

module tb;

  localparam int RUN_LIMIT  = 400000;
  localparam int LONG_HOLD  = 200;
  localparam int TAIL_WAIT  = 20;
  localparam int LAST_INDEX = (1 << csmeta_pkg::SET_IDX_W) - 1;

  // Tracks every set's metadata and the result beats still owed by the block.
  class set_meta_tracker;
    csmeta_pkg::meta_t entry [csmeta_pkg::NUM_SETS];
    csmeta_pkg::out_t  owed_meta [$];
    int    mismatches;
    int    beats_checked;
    int    mode_hits [4];

    function new();
      foreach (entry[i]) entry[i] = '0;
      mismatches    = 0;
      beats_checked = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
    endfunction

    // Apply one accepted access to the tracked set and queue the beat it returns.
    function void note_access(csmeta_pkg::in_t item);
      csmeta_pkg::meta_t m;
      csmeta_pkg::out_t  res;
      logic [3:0]  sel;
      int unsigned slot;
      slot = int'(item.set_index) % csmeta_pkg::NUM_SETS;
      m    = entry[slot];
      sel  = 4'b0001 << item.way;
      case (item.mode)
        csmeta_pkg::MODE_TOUCH: begin
          // The root records the touched half; the leaf of that half records the way.
          m.plru[2] = item.way[1];
          if (item.way[1]) m.plru[1] = item.way[0];
          else m.plru[0] = item.way[0];
        end
        csmeta_pkg::MODE_DIRTY_WR: begin
          m.dirty = item.bit_value ? (m.dirty | sel) : (m.dirty & ~sel);
        end
        csmeta_pkg::MODE_VALID_WR: begin
          m.valid = item.bit_value ? (m.valid | sel) : (m.valid & ~sel);
        end
        default: begin
        end
      endcase
      entry[slot]        = m;
      res.valid_bit      = m.valid[item.way];
      res.valid_mask     = m.valid;
      res.dirty_mask     = m.dirty;
      res.plru_bits      = m.plru;
      owed_meta.push_back(res);
      mode_hits[item.mode]++;
    endfunction

    // Compare one result beat with the oldest owed beat.
    function void check_meta(csmeta_pkg::out_t got);
      csmeta_pkg::out_t want;
      if (owed_meta.size() == 0) begin
        $error("result beat %h arrived with no access outstanding", got);
        mismatches++;
        return;
      end
      want = owed_meta.pop_front();
      beats_checked++;
      if (got.valid_bit !== want.valid_bit) begin
        $error("valid_bit: expected %0d, got %0d", want.valid_bit, got.valid_bit);
        mismatches++;
      end
      if (got.valid_mask !== want.valid_mask) begin
        $error("valid_mask: expected %h, got %h", want.valid_mask, got.valid_mask);
        mismatches++;
      end
      if (got.dirty_mask !== want.dirty_mask) begin
        $error("dirty_mask: expected %h, got %h", want.dirty_mask, got.dirty_mask);
        mismatches++;
      end
      if (got.plru_bits !== want.plru_bits) begin
        $error("plru_bits: expected %h, got %h", want.plru_bits, got.plru_bits);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return owed_meta.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  csmeta_pkg::in_t  in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  csmeta_pkg::out_t out_data_o;

  set_meta_tracker tracker = new();

  int tx_max_wait   = 10;
  int rx_max_wait   = 10;
  bit long_hold_req = 1'b0;
  int cycle_count   = 0;
  int hot_sets [8];

  cache_set_valid_dirty_plru_store_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one access beat after a random gap and hold it until it is taken.
  task automatic send_beat(csmeta_pkg::in_t item);
    int gap;
    gap = $urandom_range(0, tx_max_wait);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk); while (in_stall_o);
    tracker.note_access(item);
    @(negedge clk);
  endtask

  task automatic issue(csmeta_pkg::mode_e m, int set, int w, bit v);
    csmeta_pkg::in_t item;
    item.mode      = m;
    item.set_index = csmeta_pkg::SET_IDX_W'(set);
    item.way       = 2'(w);
    item.bit_value = v;
    send_beat(item);
  endtask

  // Random accesses, mostly to a few hot sets so that their metadata builds up.
  task automatic send_random(int count);
    csmeta_pkg::in_t item;
    repeat (count) begin
      item.mode = csmeta_pkg::mode_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) begin
        item.set_index = csmeta_pkg::SET_IDX_W'(hot_sets[$urandom_range(0, 7)]);
      end else begin
        item.set_index = csmeta_pkg::SET_IDX_W'($urandom_range(0, LAST_INDEX));
      end
      item.way       = 2'($urandom_range(0, 3));
      item.bit_value = 1'($urandom_range(0, 1));
      send_beat(item);
    end
  endtask

  // Stop offering beats until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  // Result side: random stall before each beat, with one long hold-off on request.
  initial begin : result_sink
    int hold;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold = $urandom_range(0, rx_max_wait);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
      tracker.check_meta(out_data_o);
      @(negedge clk);
    end
  end

  // Reset, directed accesses, random phases and the final verdict.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    hot_sets[0] = 0;
    hot_sets[1] = LAST_INDEX;
    for (int i = 2; i < 8; i++) hot_sets[i] = $urandom_range(0, LAST_INDEX);
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Directed: cleared sets, both extreme indexes, every mode and way.
    issue(csmeta_pkg::MODE_VALID_RD, 0, 0, 1'b0);
    issue(csmeta_pkg::MODE_VALID_RD, LAST_INDEX, 3, 1'b1);
    issue(csmeta_pkg::MODE_VALID_WR, LAST_INDEX, 3, 1'b1);
    issue(csmeta_pkg::MODE_VALID_WR, LAST_INDEX, 0, 1'b1);
    issue(csmeta_pkg::MODE_DIRTY_WR, LAST_INDEX, 3, 1'b1);
    issue(csmeta_pkg::MODE_DIRTY_WR, LAST_INDEX, 3, 1'b0);
    issue(csmeta_pkg::MODE_DIRTY_WR, LAST_INDEX, 2, 1'b1);
    issue(csmeta_pkg::MODE_TOUCH, LAST_INDEX, 0, 1'b0);
    issue(csmeta_pkg::MODE_TOUCH, LAST_INDEX, 1, 1'b1);
    issue(csmeta_pkg::MODE_TOUCH, LAST_INDEX, 2, 1'b0);
    issue(csmeta_pkg::MODE_TOUCH, LAST_INDEX, 3, 1'b1);
    issue(csmeta_pkg::MODE_TOUCH, 0, 3, 1'b0);
    issue(csmeta_pkg::MODE_TOUCH, 0, 0, 1'b0);
    issue(csmeta_pkg::MODE_TOUCH, 0, 1, 1'b1);
    issue(csmeta_pkg::MODE_TOUCH, 0, 2, 1'b0);
    issue(csmeta_pkg::MODE_VALID_RD, LAST_INDEX, 3, 1'b1);
    issue(csmeta_pkg::MODE_VALID_RD, LAST_INDEX, 1, 1'b0);
    issue(csmeta_pkg::MODE_VALID_WR, LAST_INDEX, 3, 1'b0);
    // A valid write must leave the dirty and PLRU bits of the set alone.
    issue(csmeta_pkg::MODE_DIRTY_WR, 512, 1, 1'b1);
    issue(csmeta_pkg::MODE_TOUCH, 512, 2, 1'b1);
    issue(csmeta_pkg::MODE_VALID_WR, 512, 1, 1'b1);
    issue(csmeta_pkg::MODE_VALID_WR, 512, 2, 1'b0);
    issue(csmeta_pkg::MODE_VALID_RD, 512, 1, 1'b0);
    issue(csmeta_pkg::MODE_VALID_RD, 0, 3, 1'b1);
    drain_results();

    // Random accesses with idle cycles on both sides.
    send_random(250);

    // A stretch with no idling on either side.
    tx_max_wait = 0;
    rx_max_wait = 0;
    send_random(100);
    drain_results();

    // Long output hold-off while the input keeps offering beats back to back.
    long_hold_req = 1'b1;
    send_random(60);
    drain_results();

    tx_max_wait = 10;
    rx_max_wait = 10;
    send_random(200);
    drain_results();
    repeat (TAIL_WAIT) @(negedge clk);

    $display("checked %0d result beats: %0d touches, %0d dirty writes, %0d valid writes,",
             tracker.beats_checked, tracker.mode_hits[csmeta_pkg::MODE_TOUCH],
             tracker.mode_hits[csmeta_pkg::MODE_DIRTY_WR],
             tracker.mode_hits[csmeta_pkg::MODE_VALID_WR]);
    $display("%0d reads; run included both end sets, idle-free bursts and a %0d-cycle hold-off",
             tracker.mode_hits[csmeta_pkg::MODE_VALID_RD], LONG_HOLD);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
